@@ hw/rtl/lr_pkg.sv @@
// ----------------------------------------------------------------------------
// Line rasterizer package
// Shared widths, queue sizing and the line descriptor passed from the front
// to the stepper.
// ----------------------------------------------------------------------------
package lr_pkg;

  localparam int COORD_W     = 6;
  localparam int GLYPH_W     = 8;
  localparam int ERR_W       = 9;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef logic [COORD_W-1:0] coord_t;
  typedef logic [GLYPH_W-1:0] glyph_t;

  typedef struct packed {
    logic   steep;
    logic   up;
    coord_t a0;
    coord_t a1;
    coord_t b0;
    coord_t dmaj;
    coord_t dmin;
    glyph_t glyph;
  } line_desc_t;

endpackage

@@ hw/rtl/line_rasterizer_top.sv @@
// ----------------------------------------------------------------------------
// Line rasterizer top level
// Bresenham line stepper: one pixel write per step between two grid points.
//
//   Channel   Handshake           Payload
//   command   start / busy        in_start_row, in_start_col, in_end_row,
//                                 in_end_col, in_glyph
//   pixel     out_valid strobe    out_pixel_row, out_pixel_col,
//                                 out_pixel_glyph, out_last_pixel
//
// A line of N pixels, N being the larger span plus one, is stepped out one
// pixel per cycle; queued lines follow each other without a gap.
// A command goes through the queue, stepper and pixel registers in turn.
// A two-entry command queue lets the front end take commands while the
// stepper works; busy is high only when that queue is full.
// Reset is synchronous and clears the queue and the stepper.
// The pixel receiver cannot stall; every pixel is shown for one cycle.
// ----------------------------------------------------------------------------
module line_rasterizer_top
  import lr_pkg::*;
#(
  parameter int GRID_SIZE = 64
) (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   start,
  output logic   busy,
  input  coord_t in_start_row,
  input  coord_t in_start_col,
  input  coord_t in_end_row,
  input  coord_t in_end_col,
  input  glyph_t in_glyph,
  output logic   out_valid,
  output coord_t out_pixel_row,
  output coord_t out_pixel_col,
  output glyph_t out_pixel_glyph,
  output logic   out_last_pixel
);

  logic       push, pop, full, head_valid;
  line_desc_t push_desc, head_desc;

  lr_front #(
    .GRID_SIZE(GRID_SIZE)
  ) u_front (
    .start       (start),
    .queue_full  (full),
    .in_start_row(in_start_row),
    .in_start_col(in_start_col),
    .in_end_row  (in_end_row),
    .in_end_col  (in_end_col),
    .in_glyph    (in_glyph),
    .busy        (busy),
    .push        (push),
    .push_desc   (push_desc)
  );

  lr_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_desc (push_desc),
    .pop       (pop),
    .head_valid(head_valid),
    .head_desc (head_desc),
    .full      (full)
  );

  lr_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head_valid     (head_valid),
    .head_desc      (head_desc),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_pixel_row  (out_pixel_row),
    .out_pixel_col  (out_pixel_col),
    .out_pixel_glyph(out_pixel_glyph),
    .out_last_pixel (out_last_pixel)
  );

endmodule

@@ hw/rtl/lr_front.sv @@
// ----------------------------------------------------------------------------
// Line rasterizer front end
// Accepts a line command, clamps the endpoints to the grid, picks the major
// axis, orders the endpoints and forms the spans for the stepper.
// ----------------------------------------------------------------------------
module lr_front
  import lr_pkg::*;
#(
  parameter int GRID_SIZE = 64
) (
  input  logic       start,
  input  logic       queue_full,
  input  coord_t     in_start_row,
  input  coord_t     in_start_col,
  input  coord_t     in_end_row,
  input  coord_t     in_end_col,
  input  glyph_t     in_glyph,
  output logic       busy,
  output logic       push,
  output line_desc_t push_desc
);

  localparam coord_t GRID_MAX = COORD_W'(GRID_SIZE - 1);

  coord_t r0, c0, r1, c1;
  coord_t row_span, col_span;
  coord_t a0, b0, a1, b1;
  logic   steep;

  function automatic coord_t clamp(input coord_t v);
    return (v > GRID_MAX) ? GRID_MAX : v;
  endfunction

  always_comb begin
    r0 = clamp(in_start_row);
    c0 = clamp(in_start_col);
    r1 = clamp(in_end_row);
    c1 = clamp(in_end_col);
    row_span = (r0 > r1) ? (r0 - r1) : (r1 - r0);
    col_span = (c0 > c1) ? (c0 - c1) : (c1 - c0);
    steep = col_span > row_span;
    a0 = steep ? c0 : r0;
    b0 = steep ? r0 : c0;
    a1 = steep ? c1 : r1;
    b1 = steep ? r1 : c1;
    if (a0 > a1) begin
      push_desc.a0 = a1;
      push_desc.a1 = a0;
      push_desc.b0 = b1;
      push_desc.up = b1 < b0;
    end else begin
      push_desc.a0 = a0;
      push_desc.a1 = a1;
      push_desc.b0 = b0;
      push_desc.up = b0 < b1;
    end
    push_desc.steep = steep;
    push_desc.dmaj  = steep ? col_span : row_span;
    push_desc.dmin  = steep ? row_span : col_span;
    push_desc.glyph = in_glyph;
  end

  assign busy = queue_full;
  assign push = start && !queue_full;

endmodule

@@ hw/rtl/lr_queue.sv @@
// ----------------------------------------------------------------------------
// Line rasterizer command queue
// Short first-in first-out queue of line descriptors between the front end
// and the stepper.
// ----------------------------------------------------------------------------
module lr_queue
  import lr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  line_desc_t push_desc,
  input  logic       pop,
  output logic       head_valid,
  output line_desc_t head_desc,
  output logic       full
);

  line_desc_t        slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;

  function automatic logic [QPTR_W-1:0] bump(input logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_comb begin
    wr_ptr_nxt = push ? bump(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop  ? bump(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_desc;
    end
  end

  assign head_valid = count_r != '0;
  assign head_desc  = slot_r[rd_ptr_r];
  assign full       = count_r == QCNT_W'(QUEUE_DEPTH);

endmodule

@@ hw/rtl/lr_back.sv @@
// ----------------------------------------------------------------------------
// Line rasterizer stepper
// Walks one line along its major axis, one pixel per cycle, keeping the
// doubled error term and registering each pixel write.
// ----------------------------------------------------------------------------
module lr_back
  import lr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       head_valid,
  input  line_desc_t head_desc,
  output logic       pop,
  output logic       out_valid,
  output coord_t     out_pixel_row,
  output coord_t     out_pixel_col,
  output glyph_t     out_pixel_glyph,
  output logic       out_last_pixel
);

  logic                    active_r, active_nxt;
  logic                    steep_r, steep_nxt;
  logic                    up_r, up_nxt;
  coord_t                  a_r, a_nxt;
  coord_t                  a1_r, a1_nxt;
  coord_t                  b_r, b_nxt;
  coord_t                  dmaj_r, dmaj_nxt;
  coord_t                  dmin_r, dmin_nxt;
  glyph_t                  glyph_r, glyph_nxt;
  logic signed [ERR_W-1:0] err_r, err_nxt, err_sub;
  logic                    at_end;

  logic   valid_r, valid_nxt;
  coord_t row_r, row_nxt;
  coord_t col_r, col_nxt;
  glyph_t pglyph_r, pglyph_nxt;
  logic   last_r, last_nxt;

  always_comb begin
    at_end  = a_r == a1_r;
    pop     = head_valid && (!active_r || at_end);
    err_sub = err_r - ERR_W'({dmin_r, 1'b0});

    valid_nxt  = active_r;
    row_nxt    = steep_r ? b_r : a_r;
    col_nxt    = steep_r ? a_r : b_r;
    pglyph_nxt = glyph_r;
    last_nxt   = at_end;

    active_nxt = active_r;
    steep_nxt  = steep_r;
    up_nxt     = up_r;
    a_nxt      = a_r;
    a1_nxt     = a1_r;
    b_nxt      = b_r;
    dmaj_nxt   = dmaj_r;
    dmin_nxt   = dmin_r;
    glyph_nxt  = glyph_r;
    err_nxt    = err_r;

    if (pop) begin
      active_nxt = 1'b1;
      steep_nxt  = head_desc.steep;
      up_nxt     = head_desc.up;
      a_nxt      = head_desc.a0;
      a1_nxt     = head_desc.a1;
      b_nxt      = head_desc.b0;
      dmaj_nxt   = head_desc.dmaj;
      dmin_nxt   = head_desc.dmin;
      glyph_nxt  = head_desc.glyph;
      err_nxt    = ERR_W'(head_desc.dmaj);
    end else if (active_r) begin
      if (at_end) begin
        active_nxt = 1'b0;
      end else begin
        a_nxt = a_r + 1'b1;
        if (err_sub[ERR_W-1]) begin
          err_nxt = err_sub + ERR_W'({dmaj_r, 1'b0});
          b_nxt   = up_r ? b_r + 1'b1 : b_r - 1'b1;
        end else begin
          err_nxt = err_sub;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      valid_r  <= 1'b0;
    end else begin
      active_r <= active_nxt;
      valid_r  <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    steep_r  <= steep_nxt;
    up_r     <= up_nxt;
    a_r      <= a_nxt;
    a1_r     <= a1_nxt;
    b_r      <= b_nxt;
    dmaj_r   <= dmaj_nxt;
    dmin_r   <= dmin_nxt;
    glyph_r  <= glyph_nxt;
    err_r    <= err_nxt;
    row_r    <= row_nxt;
    col_r    <= col_nxt;
    pglyph_r <= pglyph_nxt;
    last_r   <= last_nxt;
  end

  assign out_valid       = valid_r;
  assign out_pixel_row   = row_r;
  assign out_pixel_col   = col_r;
  assign out_pixel_glyph = pglyph_r;
  assign out_last_pixel  = last_r;

endmodule

@@ hw/rtl/lr_checker.sv @@
// ----------------------------------------------------------------------------
// Line rasterizer checker
// Port-level properties of the pixel stream, bound to the top level.
// ----------------------------------------------------------------------------
module lr_checker
  import lr_pkg::*;
(
  input logic   clk,
  input logic   rst_n,
  input logic   out_valid,
  input coord_t out_pixel_row,
  input coord_t out_pixel_col,
  input glyph_t out_pixel_glyph,
  input logic   out_last_pixel
);

  a_quiet_after_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("pixel beat right after reset");

  a_line_continues: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_pixel |=> out_valid)
    else $error("line stopped before its last pixel");

  a_glyph_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_pixel |=> out_pixel_glyph == $past(out_pixel_glyph))
    else $error("glyph changed within a line");

  a_unit_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_pixel |=>
      ((out_pixel_row == $past(out_pixel_row)) ||
       (out_pixel_row == $past(out_pixel_row) + 6'd1) ||
       (out_pixel_row == $past(out_pixel_row) - 6'd1)) &&
      ((out_pixel_col == $past(out_pixel_col)) ||
       (out_pixel_col == $past(out_pixel_col) + 6'd1) ||
       (out_pixel_col == $past(out_pixel_col) - 6'd1)) &&
      ((out_pixel_row != $past(out_pixel_row)) ||
       (out_pixel_col != $past(out_pixel_col))))
    else $error("consecutive pixels are not neighbors");

endmodule

bind line_rasterizer_top lr_checker u_lr_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_pixel_row  (out_pixel_row),
  .out_pixel_col  (out_pixel_col),
  .out_pixel_glyph(out_pixel_glyph),
  .out_last_pixel (out_last_pixel)
);
